@@ design/two_level_lru_cache_read_assert.svh @@
// Assertion macros for the two-level cache read block.
// Used by the checker; no other dependencies.
`ifndef TWO_LEVEL_LRU_CACHE_READ_ASSERT_SVH
`define TWO_LEVEL_LRU_CACHE_READ_ASSERT_SVH
// implication checked every clock, off during reset
`define TLC_ASSERT_IMP(lbl, clk, rstn, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (c)) \
    else $error("assertion failed");
// next-cycle implication
`define TLC_ASSERT_NXT(lbl, clk, rstn, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (c)) \
    else $error("assertion failed");
`endif

@@ design/tlc_pkg.sv @@
// Package for the two-level cache read block: constants, types, helpers.
// No dependencies.
package tlc_pkg;
  localparam int unsigned L1_SETS_DEF = 64;
  localparam int unsigned L1_WAYS_DEF = 4;
  localparam int unsigned L2_SETS_DEF = 512;
  localparam int unsigned L2_WAYS_DEF = 8;
  localparam logic [4:0] LAT_L1_HIT = 5'd5;
  localparam logic [4:0] LAT_L2_HIT = 5'd10;
  localparam logic [4:0] LAT_MEMORY = 5'd20;
  localparam logic [1:0] CFG_OFFSET   = 2'd0;
  localparam logic [1:0] CFG_L1_INDEX = 2'd1;
  localparam logic [1:0] CFG_L2_INDEX = 2'd2;
  localparam logic [1:0] CFG_L2_PRES  = 2'd3;

  typedef enum logic [1:0] {
    ST_IDLE, ST_L1_RD, ST_L2_RD, ST_OUT
  } state_e;

  typedef struct packed {
    logic       l1_hit;
    logic       l2_hit;
    logic [4:0] latency_cycles;
    logic [31:0] l1_access_count;
    logic [31:0] l1_miss_count;
    logic [31:0] l2_access_count;
    logic [31:0] l2_miss_count;
  } result_t;

  // lookup request/response between top and a level
  typedef struct packed {
    logic        rd;
    logic        upd;
    logic [31:0] addr;
    logic [3:0]  off;
    logic [3:0]  ibits;
  } lvl_req_t;

  typedef struct packed {
    logic hit;
    logic busy;
  } lvl_rsp_t;
endpackage

@@ design/tlc_if.sv @@
// Valid/ready channel interfaces for the cache read block.
// Depends on tlc_pkg.
interface tlc_addr_if;
  logic        valid;
  logic        ready;
  logic [31:0] address;
  modport source (output valid, output address, input ready);
  modport sink (input valid, input address, output ready);
endinterface

interface tlc_res_if import tlc_pkg::*; ;
  logic    valid;
  logic    ready;
  result_t res;
  modport source (output valid, output res, input ready);
  modport sink (input valid, input res, output ready);
endinterface

interface tlc_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [31:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

@@ design/tlc_level.sv @@
// One cache level: set memory with tags, valid and LRU ranks, read-modify-write.
// Depends on tlc_pkg.
module tlc_level import tlc_pkg::*; #(
  parameter int unsigned SETS = 64,
  parameter int unsigned WAYS = 4
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  lvl_req_t req_i,
  output lvl_rsp_t rsp_o
);
  localparam int unsigned SW = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int unsigned RW = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int unsigned MAXB = $clog2(SETS + 1) - 1;
  localparam int unsigned WW = 33 + RW;
  localparam int unsigned ROWW = WAYS * WW;

  // row: per way {valid, tag, rank}; swept to the reset pattern after reset
  logic [ROWW-1:0] mem [SETS];
  logic [ROWW-1:0] row_q;
  logic [SW-1:0]   set_q, set_d;
  logic [31:0]     tag_d, tag_q;
  logic [SW:0]     clr_q;
  logic [3:0]      ib;

  always_comb begin
    ib = (req_i.ibits > 4'(MAXB)) ? 4'(MAXB) : req_i.ibits;
    tag_d = 32'(64'(req_i.addr) >> (5'(req_i.off) + 5'(ib)));
    set_d = SW'((req_i.addr >> req_i.off) & ((32'd1 << ib) - 32'd1));
  end

  function automatic logic [RW-1:0] rk(logic [ROWW-1:0] r, int w);
    return r[w*WW +: RW];
  endfunction
  function automatic logic [31:0] tg(logic [ROWW-1:0] r, int w);
    return r[w*WW+RW +: 32];
  endfunction
  function automatic logic vb(logic [ROWW-1:0] r, int w);
    return r[w*WW+RW+32];
  endfunction

  // hit / victim search over the row
  logic          hit;
  logic [RW-1:0] way, vic;
  logic          anyinv;
  logic [ROWW-1:0] nrow;
  always_comb begin
    hit = 1'b0; way = '0; vic = '0; anyinv = 1'b0;
    for (int w = 0; w < WAYS; w++) begin
      if (vb(row_q, w) && tg(row_q, w) == tag_q) begin
        hit = 1'b1; way = RW'(w);
      end
    end
    for (int w = 0; w < WAYS; w++) begin
      if (!vb(row_q, w)) begin
        if (!anyinv || rk(row_q, w) > rk(row_q, int'(vic))) vic = RW'(w);
        anyinv = 1'b1;
      end
    end
    if (!anyinv) begin
      for (int w = 1; w < WAYS; w++)
        if (rk(row_q, w) > rk(row_q, int'(vic))) vic = RW'(w);
    end
    if (hit) vic = way;
    nrow = row_q;
    for (int w = 0; w < WAYS; w++) begin
      if (rk(row_q, w) < rk(row_q, int'(vic)))
        nrow[w*WW +: RW] = rk(row_q, w) + RW'(1);
    end
    nrow[int'(vic)*WW +: RW] = '0;
    if (!hit) begin
      nrow[int'(vic)*WW+RW +: 32] = tag_q;
      nrow[int'(vic)*WW+RW+32] = 1'b1;
    end
  end

  // reset pattern: all ways invalid, ranks in way order
  logic [ROWW-1:0] initrow;
  always_comb begin
    initrow = '0;
    for (int w = 0; w < WAYS; w++) initrow[w*WW +: RW] = RW'(w);
  end
  logic clearing;
  assign clearing = (clr_q != (SW+1)'(SETS));

  always_ff @(posedge clk_i) begin
    if (clearing) mem[clr_q[SW-1:0]] <= initrow;
    else if (req_i.upd) mem[set_q] <= nrow;
    if (req_i.rd) row_q <= mem[set_d];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else begin
      if (clearing) clr_q <= clr_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.rd) begin
      set_q <= set_d;
      tag_q <= tag_d;
    end
  end

  assign rsp_o.hit  = hit;
  assign rsp_o.busy = clearing;
endmodule

@@ design/two_level_lru_cache_read.sv @@
// Top level of the two-level LRU cache read block.
// Depends on tlc_pkg, tlc_if and tlc_level.
//
//  channel | dir | payload
//  addr    | in  | address[31:0]
//  res     | out | hit flags, latency, four counters
//  cfg     | in  | index[1:0], data[31:0]
//
// L1 hit or L2 absent: the load goes through the L1 read and the L1 update,
// then the result is valid. L1 miss with L2: the L2 read overlaps the L1
// update, and the L2 update follows before the result is valid.
// After reset both memories sweep their rows, one set a cycle; loads wait,
// configuration writes are taken.
// The result register holds until taken; the next load enters after that.
module two_level_lru_cache_read import tlc_pkg::*; #(
  parameter int unsigned L1_SETS = L1_SETS_DEF,
  parameter int unsigned L1_WAYS = L1_WAYS_DEF,
  parameter int unsigned L2_SETS = L2_SETS_DEF,
  parameter int unsigned L2_WAYS = L2_WAYS_DEF
) (
  input logic clk_i,
  input logic rst_ni,
  tlc_addr_if.sink  addr,
  tlc_res_if.source res,
  tlc_cfg_if.sink   cfg
);
  state_e st_q, st_d;
  logic [3:0] off_q, l1b_q, l2b_q;
  logic       l2p_q;
  logic [31:0] a_q;
  logic [31:0] c1a_q, c1m_q, c2a_q, c2m_q;
  logic        h1_q, h2_q;
  lvl_req_t r1, r2;
  lvl_rsp_t s1, s2;

  tlc_level #(.SETS(L1_SETS), .WAYS(L1_WAYS)) u_l1 (
    .clk_i, .rst_ni, .req_i(r1), .rsp_o(s1));
  tlc_level #(.SETS(L2_SETS), .WAYS(L2_WAYS)) u_l2 (
    .clk_i, .rst_ni, .req_i(r2), .rsp_o(s2));

  assign cfg.ready  = 1'b1;
  assign addr.ready = (st_q == ST_IDLE) && !s1.busy && !s2.busy;

  always_comb begin
    st_d = st_q;
    r1 = '{rd: 1'b0, upd: 1'b0, addr: addr.address, off: off_q, ibits: {1'b0, l1b_q[2:0]}};
    r2 = '{rd: 1'b0, upd: 1'b0, addr: a_q, off: off_q, ibits: l2b_q};
    unique case (st_q)
      ST_IDLE: if (addr.valid && addr.ready) begin
        r1.rd = 1'b1; st_d = ST_L1_RD;
      end
      ST_L1_RD: begin
        r1.upd = 1'b1;
        if (s1.hit || !l2p_q) st_d = ST_OUT;
        else begin
          r2.rd = 1'b1; st_d = ST_L2_RD;
        end
      end
      ST_L2_RD: begin
        r2.upd = 1'b1; st_d = ST_OUT;
      end
      ST_OUT: if (res.ready) st_d = ST_IDLE;
      default: st_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_IDLE;
      off_q <= 4'd5; l1b_q <= 4'd6; l2b_q <= 4'd9; l2p_q <= 1'b1;
      c1a_q <= '0; c1m_q <= '0; c2a_q <= '0; c2m_q <= '0;
    end else begin
      st_q <= st_d;
      if (cfg.valid) begin
        unique case (cfg.index)
          CFG_OFFSET:   off_q <= cfg.data[3:0];
          CFG_L1_INDEX: l1b_q <= {1'b0, cfg.data[2:0]};
          CFG_L2_INDEX: l2b_q <= cfg.data[3:0];
          CFG_L2_PRES:  l2p_q <= cfg.data[0];
          default: ;
        endcase
      end
      if (st_q == ST_IDLE && st_d == ST_L1_RD) c1a_q <= c1a_q + 32'd1;
      if (st_q == ST_L1_RD && !s1.hit) begin
        c1m_q <= c1m_q + 32'd1;
        if (l2p_q) c2a_q <= c2a_q + 32'd1;
      end
      if (st_q == ST_L2_RD && !s2.hit) c2m_q <= c2m_q + 32'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (st_q == ST_IDLE) a_q <= addr.address;
    if (st_q == ST_L1_RD) begin
      h1_q <= s1.hit; h2_q <= 1'b0;
    end
    if (st_q == ST_L2_RD) h2_q <= s2.hit;
  end

  assign res.valid = (st_q == ST_OUT);
  always_comb begin
    res.res.l1_hit = h1_q;
    res.res.l2_hit = h2_q;
    res.res.latency_cycles = h1_q ? LAT_L1_HIT : (h2_q ? LAT_L2_HIT : LAT_MEMORY);
    res.res.l1_access_count = c1a_q;
    res.res.l1_miss_count = c1m_q;
    res.res.l2_access_count = c2a_q;
    res.res.l2_miss_count = c2m_q;
  end
endmodule

@@ design/tlc_checker.sv @@
// Port-level checker for the two-level cache read block, with bind.
// Depends on tlc_pkg and the assertion macro header.
`include "two_level_lru_cache_read_assert.svh"
module tlc_checker import tlc_pkg::*; (
  input logic    clk_i,
  input logic    rst_ni,
  input logic    in_v,
  input logic    in_r,
  input logic    out_v,
  input logic    out_r,
  input result_t r
);
  `TLC_ASSERT_IMP(a_busy, clk_i, rst_ni, out_v, !in_r)
  `TLC_ASSERT_NXT(a_acc, clk_i, rst_ni, in_v && in_r, !in_r)
  `TLC_ASSERT_IMP(a_excl, clk_i, rst_ni, out_v, !(r.l1_hit && r.l2_hit))
  `TLC_ASSERT_IMP(a_lat, clk_i, rst_ni, out_v && r.l1_hit, r.latency_cycles == LAT_L1_HIT)
  `TLC_ASSERT_NXT(a_hold, clk_i, rst_ni, out_v && !out_r, out_v && $stable(r))
endmodule

bind two_level_lru_cache_read tlc_checker u_chk (
  .clk_i, .rst_ni, .in_v(addr.valid), .in_r(addr.ready),
  .out_v(res.valid), .out_r(res.ready), .r(res.res));

@@ tb/two_level_lru_cache_read_tb.sv @@
// Testbench for the two-level LRU cache read block: address, result and config channels.
// Depends on tlc_pkg, tlc_if and the block itself; predicts each result with its own cache copy.
`timescale 1ns / 1ps

module two_level_lru_cache_read_tb;
  import tlc_pkg::*;

  localparam int unsigned L1S = L1_SETS_DEF;
  localparam int unsigned L1W = L1_WAYS_DEF;
  localparam int unsigned L2S = L2_SETS_DEF;
  localparam int unsigned L2W = L2_WAYS_DEF;
  localparam int unsigned L1_MAXB = $clog2(L1S);
  localparam int unsigned L2_MAXB = $clog2(L2S);
  localparam longint unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned N_RANDOM = 1880;
  localparam int unsigned N_DIRECTED = 16;

  logic clk;
  logic rst_n;

  tlc_addr_if addr_ch ();
  tlc_res_if  res_ch ();
  tlc_cfg_if  cfg_ch ();

  two_level_lru_cache_read i_dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .addr  (addr_ch.sink),
    .res   (res_ch.source),
    .cfg   (cfg_ch.sink)
  );

  // Predictor state: tag, valid and rank per way, counters, register copy.
  logic [31:0] l1_tag [];
  logic        l1_vld [];
  int unsigned l1_rank [];
  logic [31:0] l2_tag [];
  logic        l2_vld [];
  int unsigned l2_rank [];
  logic [31:0] n_l1_acc, n_l1_miss, n_l2_acc, n_l2_miss;
  logic [3:0]  cfg_off;
  logic [2:0]  cfg_l1_ib;
  logic [3:0]  cfg_l2_ib;
  logic        cfg_l2_on;

  result_t     pending_results[$];
  int unsigned n_errors;
  int unsigned n_sent;
  int unsigned n_taken;
  int unsigned n_l1_hits, n_l2_hits;
  longint unsigned cycles;
  bit          long_stall;

  // Directed rows: address, and whether the expected result is written in.
  typedef struct {
    logic [31:0] address;
    bit          fixed;
    logic        l1_hit;
    logic        l2_hit;
    logic [4:0]  lat;
  } dir_row_t;
  dir_row_t dir_rows [N_DIRECTED];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("Verification failed");
      $finish;
    end
  end

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    n_errors++;
    $display("MISMATCH %s: got %0d expected %0d (result %0d)", what, got, want, n_taken);
  endtask

  // Refresh ranks after a way is touched: younger ways age by one.
  function automatic void touch(ref int unsigned rk [], input int unsigned base,
                                input int unsigned ways, input int unsigned w);
    int unsigned r;
    r = rk[base + w];
    for (int unsigned i = 0; i < ways; i++)
      if (rk[base + i] < r) rk[base + i]++;
    rk[base + w] = 0;
  endfunction

  function automatic bit level_lookup(ref logic [31:0] tg [], ref logic vd [],
                                      ref int unsigned rk [], input int unsigned ways,
                                      input int unsigned maxb, input int unsigned ib_reg,
                                      input logic [31:0] a);
    int unsigned ib, base, victim;
    logic [31:0] tag, set;
    bit hit, any_inv;
    ib = ib_reg < maxb ? ib_reg : maxb;
    tag = 32'(64'(a) >> (cfg_off + ib));
    set = (a >> cfg_off) & ((32'd1 << ib) - 32'd1);
    base = set * ways;
    hit = 0;
    any_inv = 0;
    victim = 0;
    for (int unsigned w = 0; w < ways; w++)
      if (vd[base + w] && tg[base + w] == tag) begin
        hit = 1;
        victim = w;
      end
    if (hit) begin
      touch(rk, base, ways, victim);
      return 1;
    end
    // fill: highest-ranked invalid way first, else the oldest way
    for (int unsigned w = 0; w < ways; w++)
      if (!vd[base + w]) begin
        if (!any_inv || rk[base + w] > rk[base + victim]) victim = w;
        any_inv = 1;
      end
    if (!any_inv)
      for (int unsigned w = 1; w < ways; w++)
        if (rk[base + w] > rk[base + victim]) victim = w;
    touch(rk, base, ways, victim);
    tg[base + victim] = tag;
    vd[base + victim] = 1'b1;
    return 0;
  endfunction

  function automatic result_t predict_load(input logic [31:0] a);
    result_t r;
    bit h1, h2;
    h2 = 0;
    n_l1_acc++;
    h1 = level_lookup(l1_tag, l1_vld, l1_rank, L1W, L1_MAXB, cfg_l1_ib, a);
    if (!h1) begin
      n_l1_miss++;
      if (cfg_l2_on) begin
        n_l2_acc++;
        h2 = level_lookup(l2_tag, l2_vld, l2_rank, L2W, L2_MAXB, cfg_l2_ib, a);
        if (!h2) n_l2_miss++;
      end
    end
    r.l1_hit = h1;
    r.l2_hit = h2;
    r.latency_cycles = h1 ? LAT_L1_HIT : (h2 ? LAT_L2_HIT : LAT_MEMORY);
    r.l1_access_count = n_l1_acc;
    r.l1_miss_count = n_l1_miss;
    r.l2_access_count = n_l2_acc;
    r.l2_miss_count = n_l2_miss;
    return r;
  endfunction

  task automatic predictor_reset();
    l1_tag = new[L1S*L1W];
    l1_vld = new[L1S*L1W];
    l1_rank = new[L1S*L1W];
    l2_tag = new[L2S*L2W];
    l2_vld = new[L2S*L2W];
    l2_rank = new[L2S*L2W];
    foreach (l1_vld[i]) begin
      l1_vld[i] = 1'b0;
      l1_tag[i] = '0;
      l1_rank[i] = i % L1W;
    end
    foreach (l2_vld[i]) begin
      l2_vld[i] = 1'b0;
      l2_tag[i] = '0;
      l2_rank[i] = i % L2W;
    end
    n_l1_acc = 0;
    n_l1_miss = 0;
    n_l2_acc = 0;
    n_l2_miss = 0;
    cfg_off = 4'd5;
    cfg_l1_ib = 3'd6;
    cfg_l2_ib = 4'd9;
    cfg_l2_on = 1'b1;
  endtask

  // One register write; only called with the block idle, valid left high.
  task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    case (idx)
      CFG_OFFSET:   cfg_off   = value[3:0];
      CFG_L1_INDEX: cfg_l1_ib = value[2:0];
      CFG_L2_INDEX: cfg_l2_ib = value[3:0];
      CFG_L2_PRES:  cfg_l2_on = value[0];
      default: ;
    endcase
  endtask

  task automatic set_config(input int unsigned off, input int unsigned ib1,
                            input int unsigned ib2, input int unsigned l2on);
    write_reg(CFG_OFFSET, 32'(off) | (32'($urandom) & 32'hFFFF_FFF0));
    write_reg(CFG_L1_INDEX, 32'(ib1));
    write_reg(CFG_L2_INDEX, 32'(ib2));
    write_reg(CFG_L2_PRES, 32'(l2on));
    cfg_ch.valid <= 1'b0;
  endtask

  // Send one load; a fixed expectation overrides only the directly readable fields.
  task automatic send_load(input logic [31:0] a, input bit fixed, input logic h1,
                           input logic h2, input logic [4:0] lat);
    result_t r;
    int unsigned gap;
    gap = $urandom_range(0, 10);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap != 0) begin
      addr_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    addr_ch.valid   <= 1'b1;
    addr_ch.address <= a;
    do @(posedge clk); while (!addr_ch.ready);
    r = predict_load(a);
    if (fixed) begin
      r.l1_hit = h1;
      r.l2_hit = h2;
      r.latency_cycles = lat;
    end
    pending_results.push_back(r);
    n_sent++;
  endtask

  task automatic drain();
    addr_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  // Result side: random hold-off per result, plus one long stall.
  initial begin
    int unsigned wait_n;
    res_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (long_stall) begin
        res_ch.ready <= 1'b0;
        repeat (300) @(posedge clk);
        long_stall = 0;
      end
      wait_n = $urandom_range(0, 10);
      if ($urandom_range(0, 3) == 0) wait_n = 0;
      repeat (wait_n) @(posedge clk);
      res_ch.ready <= 1'b1;
      do @(posedge clk); while (!(res_ch.valid && res_ch.ready));
      res_ch.ready <= 1'b0;
    end
  end

  // Check each transfer on the result channel against the oldest expectation.
  always @(posedge clk) begin
    result_t got, want;
    if (rst_n && res_ch.valid && res_ch.ready) begin
      got = res_ch.res;
      if (pending_results.size() == 0) begin
        n_errors++;
        $display("MISMATCH unexpected result, l1_access_count %0d", got.l1_access_count);
      end else begin
        want = pending_results.pop_front();
        if (got.l1_hit !== want.l1_hit)
          report("l1_hit", 32'(got.l1_hit), 32'(want.l1_hit));
        if (got.l2_hit !== want.l2_hit)
          report("l2_hit", 32'(got.l2_hit), 32'(want.l2_hit));
        if (got.latency_cycles !== want.latency_cycles)
          report("latency_cycles", 32'(got.latency_cycles), 32'(want.latency_cycles));
        if (got.l1_access_count !== want.l1_access_count)
          report("l1_access_count", got.l1_access_count, want.l1_access_count);
        if (got.l1_miss_count !== want.l1_miss_count)
          report("l1_miss_count", got.l1_miss_count, want.l1_miss_count);
        if (got.l2_access_count !== want.l2_access_count)
          report("l2_access_count", got.l2_access_count, want.l2_access_count);
        if (got.l2_miss_count !== want.l2_miss_count)
          report("l2_miss_count", got.l2_miss_count, want.l2_miss_count);
        if (got.l1_hit) n_l1_hits++;
        if (got.l2_hit) n_l2_hits++;
      end
      n_taken++;
    end
  end

  // Random address: mostly reuse of a small working set, so sets fill and evict.
  function automatic logic [31:0] pick_addr(ref logic [31:0] pool [$]);
    logic [31:0] a;
    int unsigned sel;
    sel = $urandom_range(0, 9);
    if (sel < 6 && pool.size() != 0) begin
      a = pool[$urandom_range(0, pool.size() - 1)];
      if ($urandom_range(0, 1)) a = a ^ (32'($urandom_range(0, 31)));
    end else if (sel < 8) begin
      // low bits in a small range, new upper tag: conflict pressure
      a = {12'($urandom), 20'($urandom_range(0, 255))};
      pool.push_back(a);
      if (pool.size() > 40) void'(pool.pop_front());
    end else begin
      a = $urandom;
    end
    return a;
  endfunction

  initial begin
    logic [31:0] pool [$];
    int unsigned phase;
    n_errors = 0;
    n_sent = 0;
    n_taken = 0;
    n_l1_hits = 0;
    n_l2_hits = 0;
    cycles = 0;
    long_stall = 0;
    rst_n = 1'b0;
    addr_ch.valid = 1'b0;
    addr_ch.address = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = CFG_OFFSET;
    cfg_ch.data = '0;
    predictor_reset();

    // After reset every first touch misses both levels.
    dir_rows[0]  = '{32'h0000_0000, 1, 1'b0, 1'b0, LAT_MEMORY};
    dir_rows[1]  = '{32'h0000_0000, 1, 1'b1, 1'b0, LAT_L1_HIT};
    dir_rows[2]  = '{32'hFFFF_FFFF, 1, 1'b0, 1'b0, LAT_MEMORY};
    dir_rows[3]  = '{32'hFFFF_FFE0, 1, 1'b1, 1'b0, LAT_L1_HIT};
    dir_rows[4]  = '{32'h0000_001F, 1, 1'b1, 1'b0, LAT_L1_HIT};
    // five tags into L1 set 0: the first is evicted from L1 but stays in L2
    dir_rows[5]  = '{32'h0000_1000, 0, 0, 0, 0};
    dir_rows[6]  = '{32'h0000_2000, 0, 0, 0, 0};
    dir_rows[7]  = '{32'h0000_3000, 0, 0, 0, 0};
    dir_rows[8]  = '{32'h0000_4000, 0, 0, 0, 0};
    dir_rows[9]  = '{32'h0000_0000, 0, 0, 0, 0};
    dir_rows[10] = '{32'h0000_2000, 0, 0, 0, 0};
    dir_rows[11] = '{32'hAAAA_AAAA, 0, 0, 0, 0};
    dir_rows[12] = '{32'h5555_5555, 0, 0, 0, 0};
    dir_rows[13] = '{32'h8000_0000, 0, 0, 0, 0};
    dir_rows[14] = '{32'h0000_1000, 0, 0, 0, 0};
    dir_rows[15] = '{32'h7FFF_FFFF, 0, 0, 0, 0};

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < N_DIRECTED; i++)
      send_load(dir_rows[i].address, dir_rows[i].fixed, dir_rows[i].l1_hit,
                dir_rows[i].l2_hit, dir_rows[i].lat);
    drain();

    // L2 absent and oversized index registers saturate.
    set_config(0, 7, 15, 0);
    send_load(32'h0000_0040, 0, 0, 0, 0);
    send_load(32'h1234_5678, 0, 0, 0, 0);
    send_load(32'h0000_0040, 0, 0, 0, 0);
    drain();

    // Random phases over a spread of settings, extremes included.
    for (phase = 0; phase < 8; phase++) begin
      case (phase)
        0: set_config(5, 6, 9, 1);
        1: set_config(0, 0, 0, 1);
        2: set_config(8, 6, 9, 1);
        3: set_config(15, 2, 3, 1);
        4: set_config(2, 1, 4, 0);
        default: set_config($urandom_range(0, 8), $urandom_range(0, 7),
                             $urandom_range(0, 15), $urandom_range(0, 1));
      endcase
      if (phase == 2) long_stall = 1;
      for (int unsigned k = 0; k < N_RANDOM / 8; k++)
        send_load(pick_addr(pool), 0, 0, 0, 0);
      drain();
    end

    $display("%0d loads checked over 10 register settings, L2 on and off", n_taken);
    $display("%0d L1 hits, %0d L2 hits, %0d mismatches", n_l1_hits, n_l2_hits, n_errors);
    if (n_errors == 0 && pending_results.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
